// ===== rtl/b64d_pkg.sv =====
// b64d_pkg: shared types, constants and the symbol classifier for the base64 decoder
// depends on nothing; used by b64d_front, b64d_back and base64_to_word_decoder
package b64d_pkg;

  // default sizes
  localparam int MAX_WORDS_DEF   = 4096;
  localparam int LAYER_COUNT_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  // field widths
  localparam int CHAR_W  = 8;
  localparam int LAYER_W = 4;
  localparam int SYM_W   = 6;
  localparam int WORD_W  = 32;
  localparam int WIDX_W  = 12;

  // ascii codes of the alphabet bounds
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // symbol values of the special characters
  localparam logic [5:0] SYM_LO_BASE  = 6'd26;
  localparam logic [5:0] SYM_DIG_BASE = 6'd52;
  localparam logic [5:0] SYM_PLUS     = 6'd62;
  localparam logic [5:0] SYM_SLASH    = 6'd63;

  // classified character
  typedef struct packed {
    logic             is_sym;
    logic [SYM_W-1:0] val;
  } sym_class_t;

  // beat from front to back
  typedef struct packed {
    logic               is_sym;
    logic [SYM_W-1:0]   sym;
    logic [LAYER_W-1:0] layer;
    logic               first;
    logic               last;
  } sym_beat_t;

  // result beat
  typedef struct packed {
    logic [WORD_W-1:0]  tile_word;
    logic [WIDX_W-1:0]  word_index;
    logic [LAYER_W-1:0] layer_out;
    logic               word_valid;
    logic               end_of_text;
    logic               overflow;
  } result_t;

  // map an ascii code to its 6-bit symbol; is_sym low ends decoding
  function automatic sym_class_t classify(input logic [CHAR_W-1:0] c);
    sym_class_t r;
    r.is_sym = 1'b1;
    r.val    = '0;
    priority if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r.val = 6'(c - CH_UP_A);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      r.val = 6'(c - CH_LO_A) + SYM_LO_BASE;
    end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
      r.val = 6'(c - CH_DIG_0) + SYM_DIG_BASE;
    end else if (c == CH_PLUS) begin
      r.val = SYM_PLUS;
    end else if (c == CH_SLASH) begin
      r.val = SYM_SLASH;
    end else begin
      r.is_sym = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/b64d_fifo.sv =====
// b64d_fifo: small register-based show-ahead queue, parameterized width and depth
// depends on nothing; instanced between front and back and on the result side
module b64d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/b64d_front.sv =====
// b64d_front: accepts characters, classifies them and clamps the layer number
// depends on b64d_pkg
module b64d_front #(
  parameter int LAYER_COUNT = b64d_pkg::LAYER_COUNT_DEF
) (
  input  logic [b64d_pkg::CHAR_W-1:0]  char_code,
  input  logic [b64d_pkg::LAYER_W-1:0] layer_sel,
  input  logic                         first_char,
  input  logic                         last_char,
  output b64d_pkg::sym_beat_t          beat
);

  b64d_pkg::sym_class_t cls;
  logic [8:0]           layer_wide;

  // symbol lookup
  assign cls = b64d_pkg::classify(char_code);

  // layer clamp to the last layer
  assign layer_wide = 9'(layer_sel);

  always_comb begin
    beat.is_sym = cls.is_sym;
    beat.sym    = cls.val;
    beat.first  = first_char;
    beat.last   = last_char;
    if (layer_wide >= 9'(LAYER_COUNT)) begin
      beat.layer = b64d_pkg::LAYER_W'(LAYER_COUNT - 1);
    end else begin
      beat.layer = layer_sel;
    end
  end

endmodule

// ===== rtl/b64d_back.sv =====
// b64d_back: rebuilds bytes from sextets, packs words and forms result beats
// depends on b64d_pkg
module b64d_back #(
  parameter int MAX_WORDS = b64d_pkg::MAX_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  b64d_pkg::sym_beat_t beat,
  input  logic                beat_empty,
  output logic                beat_pop,
  input  logic                res_full,
  output logic                res_push,
  output b64d_pkg::result_t   res
);

  localparam int IDX_W = $clog2(MAX_WORDS + 1);
  localparam int IW    = (IDX_W > b64d_pkg::WIDX_W) ? IDX_W : b64d_pkg::WIDX_W;

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       pbyte_r, pbyte_nxt;
  logic [1:0]       biw_r, biw_nxt;
  logic [23:0]      acc_r, acc_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             stopped_r, stopped_nxt;
  logic             ovf_r, ovf_nxt;

  logic             emit;
  logic             have_word;
  logic             valid;
  logic             got;
  logic [7:0]       b;
  logic [31:0]      word;
  logic [IDX_W-1:0] widx;
  logic [IW-1:0]    widx_wide;

  // take a beat whenever the result queue has room
  assign beat_pop = !beat_empty && !res_full;
  assign res_push = beat_pop && emit;

  // decode step
  always_comb begin
    phase_nxt   = phase_r;
    pbyte_nxt   = pbyte_r;
    biw_nxt     = biw_r;
    acc_nxt     = acc_r;
    idx_nxt     = idx_r;
    stopped_nxt = stopped_r;
    ovf_nxt     = ovf_r;
    have_word   = 1'b0;
    valid       = 1'b0;
    got         = 1'b0;
    b           = '0;
    word        = '0;
    widx        = '0;

    // new text clears everything first
    if (beat.first) begin
      phase_nxt   = '0;
      pbyte_nxt   = '0;
      biw_nxt     = '0;
      acc_nxt     = '0;
      idx_nxt     = '0;
      stopped_nxt = 1'b0;
      ovf_nxt     = 1'b0;
    end

    if (!stopped_nxt) begin
      if (!beat.is_sym) begin
        stopped_nxt = 1'b1;
      end else begin
        unique case (phase_nxt)
          2'd0: begin
            pbyte_nxt = {beat.sym, 2'b00};
          end
          2'd1: begin
            b         = pbyte_nxt | {6'b0, beat.sym[5:4]};
            pbyte_nxt = {beat.sym[3:0], 4'b0};
            got       = 1'b1;
          end
          2'd2: begin
            b         = pbyte_nxt | {4'b0, beat.sym[5:2]};
            pbyte_nxt = {beat.sym[1:0], 6'b0};
            got       = 1'b1;
          end
          default: begin
            b         = pbyte_nxt | {2'b0, beat.sym};
            pbyte_nxt = '0;
            got       = 1'b1;
          end
        endcase
        phase_nxt = phase_nxt + 2'd1;

        // byte into the word under construction
        if (got) begin
          if (biw_nxt == 2'd3) begin
            if (idx_nxt < IDX_W'(MAX_WORDS)) begin
              have_word = 1'b1;
              word      = {b, acc_nxt};
              widx      = idx_nxt;
              idx_nxt   = idx_nxt + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
            acc_nxt = '0;
            biw_nxt = '0;
          end else begin
            unique case (biw_nxt)
              2'd0:    acc_nxt[7:0]   = b;
              2'd1:    acc_nxt[15:8]  = b;
              default: acc_nxt[23:16] = b;
            endcase
            biw_nxt = biw_nxt + 2'd1;
          end
        end
      end
    end

    valid = have_word;

    // flush of a partial word on the end mark
    if (beat.last && !have_word && biw_nxt != 2'd0) begin
      if (idx_nxt < IDX_W'(MAX_WORDS)) begin
        valid = 1'b1;
        word  = {8'b0, acc_nxt};
        widx  = idx_nxt;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (!valid) begin
      word = '0;
      widx = '0;
    end

    emit = beat.last || have_word;
  end

  // result beat
  assign widx_wide = IW'(widx);

  always_comb begin
    res.tile_word   = word;
    res.word_index  = widx_wide[b64d_pkg::WIDX_W-1:0];
    res.layer_out   = beat.layer;
    res.word_valid  = valid;
    res.end_of_text = beat.last;
    res.overflow    = ovf_nxt;
  end

  // decode state; the end mark clears the text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      pbyte_r   <= '0;
      biw_r     <= '0;
      acc_r     <= '0;
      idx_r     <= '0;
      stopped_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else if (beat_pop) begin
      if (beat.last) begin
        phase_r   <= '0;
        pbyte_r   <= '0;
        biw_r     <= '0;
        acc_r     <= '0;
        idx_r     <= '0;
        stopped_r <= 1'b0;
        ovf_r     <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        pbyte_r   <= pbyte_nxt;
        biw_r     <= biw_nxt;
        acc_r     <= acc_nxt;
        idx_r     <= idx_nxt;
        stopped_r <= stopped_nxt;
        ovf_r     <= ovf_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // word index never passes the store size
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(MAX_WORDS))
    else $error("word index beyond store size");

  // an end mark leaves a clean text behind
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    beat_pop && beat.last |=> idx_r == '0 && biw_r == '0 && !stopped_r && !ovf_r)
    else $error("decode state not cleared after end mark");

  // results only come from a taken beat
  a_push_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> beat_pop)
    else $error("result pushed without a beat");

  // a valid word is never emitted once the index is saturated
  a_valid_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.word_valid && !beat.first |-> idx_r < IDX_W'(MAX_WORDS))
    else $error("word emitted past store size");
`endif

endmodule

// ===== rtl/base64_to_word_decoder.sv =====
// base64_to_word_decoder: top level; front classifier, beat queue, decode back end, result queue
// depends on b64d_pkg, b64d_fifo, b64d_front, b64d_back
//
//  channel   handshake          beat fields
//  input     push / full        in_char_code, in_layer_sel, in_first_char, in_last_char
//  result    pop / empty        out_tile_word, out_word_index, out_layer_out,
//                               out_word_valid, out_end_of_text, out_overflow
//
// one character per cycle sustained while the result side keeps up; an accepted character passes
// through the beat queue, then the result queue, both 2 deep
// the back end takes a beat whenever the result queue is not full; a stalled
// result side fills the result queue, then the beat queue, then raises full
// synchronous active-low reset empties both queues and clears the decode state
module base64_to_word_decoder #(
  parameter int MAX_WORDS   = b64d_pkg::MAX_WORDS_DEF,
  parameter int LAYER_COUNT = b64d_pkg::LAYER_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [b64d_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [b64d_pkg::LAYER_W-1:0]  in_layer_sel,
  input  logic                          in_first_char,
  input  logic                          in_last_char,
  output logic                          empty,
  input  logic                          pop,
  output logic [b64d_pkg::WORD_W-1:0]   out_tile_word,
  output logic [b64d_pkg::WIDX_W-1:0]   out_word_index,
  output logic [b64d_pkg::LAYER_W-1:0]  out_layer_out,
  output logic                          out_word_valid,
  output logic                          out_end_of_text,
  output logic                          out_overflow
);

  localparam int BEAT_W = $bits(b64d_pkg::sym_beat_t);
  localparam int RES_W  = $bits(b64d_pkg::result_t);

  b64d_pkg::sym_beat_t front_beat, back_beat;
  b64d_pkg::result_t   back_res, out_res;
  logic [BEAT_W-1:0]   beat_rdata;
  logic [RES_W-1:0]    res_rdata;
  logic                beat_empty, beat_pop;
  logic                res_full, res_push;

  // classify
  b64d_front #(.LAYER_COUNT(LAYER_COUNT)) u_front (
    .char_code  (in_char_code),
    .layer_sel  (in_layer_sel),
    .first_char (in_first_char),
    .last_char  (in_last_char),
    .beat       (front_beat)
  );

  // queue between front and back
  b64d_fifo #(.WIDTH(BEAT_W), .DEPTH(b64d_pkg::QUEUE_DEPTH)) u_beat_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_beat),
    .full  (full),
    .pop   (beat_pop),
    .rdata (beat_rdata),
    .empty (beat_empty)
  );

  assign back_beat = b64d_pkg::sym_beat_t'(beat_rdata);

  // decode
  b64d_back #(.MAX_WORDS(MAX_WORDS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (back_beat),
    .beat_empty (beat_empty),
    .beat_pop   (beat_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res)
  );

  // result queue
  b64d_fifo #(.WIDTH(RES_W), .DEPTH(b64d_pkg::QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign out_res         = b64d_pkg::result_t'(res_rdata);
  assign out_tile_word   = out_res.tile_word;
  assign out_word_index  = out_res.word_index;
  assign out_layer_out   = out_res.layer_out;
  assign out_word_valid  = out_res.word_valid;
  assign out_end_of_text = out_res.end_of_text;
  assign out_overflow    = out_res.overflow;

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for base64_to_word_decoder, directed rows then random texts
// depends on b64d_pkg and the rtl of base64_to_word_decoder; reads no files
// results are predicted per character and compared field by field in order
module tb;
  import b64d_pkg::*;

  localparam int MAX_W      = MAX_WORDS_DEF;
  localparam int LAYERS     = LAYER_COUNT_DEF;
  localparam int RAND_ITEMS = 850;
  localparam int WDOG_LIMIT = 2000;
  localparam int SHOW_MAX   = 10;
  localparam int TAIL_WAIT  = 8;
  localparam logic [7:0] PAD_CHAR = "=";

  // one character beat as driven on the input side
  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [LAYER_W-1:0] layer;
    logic               first;
    logic               last;
  } char_beat_t;

  // directed row: beat plus an optional hand-written result
  typedef struct packed {
    char_beat_t beat;
    logic       typed;
    result_t    res;
  } dir_row_t;

  localparam result_t NO_RES = '0;
  localparam int DIR_N = 25;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // single symbol right after reset: no complete byte, empty close
    '{'{"A", 4'd0, 1'b1, 1'b1}, 1'b1, '{32'h0, 12'd0, 4'd0, 1'b0, 1'b1, 1'b0}},
    // all-ones word completing on the end mark, top layer
    '{'{"/", 4'd15, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{"/", 4'd15, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"/", 4'd15, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"/", 4'd15, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"/", 4'd15, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"/", 4'd15, 1'b0, 1'b1}, 1'b1, '{32'hffff_ffff, 12'd0, 4'd15, 1'b1, 1'b1, 1'b0}},
    // full word, padding stop, ignored junk, pad on the end mark
    '{'{"T", 4'd2, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{"W", 4'd2, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"F", 4'd2, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"u", 4'd2, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"Z", 4'd2, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"A", 4'd2, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{PAD_CHAR, 4'd2, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"x", 4'd2, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{PAD_CHAR, 4'd2, 1'b0, 1'b1}, 1'b0, NO_RES},
    // new text without a first mark, stopped by a control code, partial flush
    '{'{"+", 4'd9, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"9", 4'd9, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"a", 4'd9, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00, 4'd9, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{8'hff, 4'd9, 1'b0, 1'b1}, 1'b0, NO_RES},
    // two-byte flush across letters and digits
    '{'{"Z", 4'd3, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{"0", 4'd3, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{'{"z", 4'd3, 1'b0, 1'b1}, 1'b0, NO_RES},
    // first and last on one character
    '{'{"z", 4'd7, 1'b1, 1'b1}, 1'b1, '{32'h0, 12'd0, 4'd7, 1'b0, 1'b1, 1'b0}}
  };

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  logic [CHAR_W-1:0]   in_char_code;
  logic [LAYER_W-1:0]  in_layer_sel;
  logic                in_first_char;
  logic                in_last_char;
  logic                empty;
  logic                pop;
  logic [WORD_W-1:0]   out_tile_word;
  logic [WIDX_W-1:0]   out_word_index;
  logic [LAYER_W-1:0]  out_layer_out;
  logic                out_word_valid;
  logic                out_end_of_text;
  logic                out_overflow;

  // predicted decode state
  logic [1:0]  sym_phase;
  logic [7:0]  part_byte;
  logic [1:0]  byte_cnt;
  logic [23:0] word_acc;
  int          next_idx;
  logic        stop_seen;
  logic        ovf_seen;

  result_t pending_results [$];
  int      mismatch_count;
  int      fail_count;
  int      idle_cycles;
  bit      idle_on;

  base64_to_word_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_char_code    (in_char_code),
    .in_layer_sel    (in_layer_sel),
    .in_first_char   (in_first_char),
    .in_last_char    (in_last_char),
    .empty           (empty),
    .pop             (pop),
    .out_tile_word   (out_tile_word),
    .out_word_index  (out_word_index),
    .out_layer_out   (out_layer_out),
    .out_word_valid  (out_word_valid),
    .out_end_of_text (out_end_of_text),
    .out_overflow    (out_overflow)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_text_state();
    sym_phase = '0;
    part_byte = '0;
    byte_cnt  = '0;
    word_acc  = '0;
    next_idx  = 0;
    stop_seen = 1'b0;
    ovf_seen  = 1'b0;
  endfunction

  // 6-bit value of a base64 character, -1 for anything that ends decoding
  function automatic int sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  // character for a 6-bit value
  function automatic logic [7:0] char_of(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
  endfunction

  // advance the decode state by one character; 1 when a result is due
  function automatic bit decode_char(input char_beat_t b, output result_t r);
    int          sym;
    logic [7:0]  byte_val;
    logic [31:0] w;
    logic [11:0] idx;
    logic [3:0]  lay;
    bit          got;
    bit          have;
    bit          valid;
    r        = '0;
    byte_val = '0;
    w        = '0;
    idx      = '0;
    got      = 1'b0;
    have     = 1'b0;
    lay      = (b.layer >= LAYERS) ? 4'(LAYERS - 1) : b.layer;
    if (b.first) clear_text_state();
    if (!stop_seen) begin
      sym = sextet_of(b.ch);
      if (sym < 0) begin
        stop_seen = 1'b1;
      end else begin
        case (sym_phase)
          2'd0: begin
            part_byte = 8'(sym << 2);
          end
          2'd1: begin
            byte_val  = part_byte | 8'(sym >> 4);
            part_byte = 8'(sym << 4);
            got       = 1'b1;
          end
          2'd2: begin
            byte_val  = part_byte | 8'(sym >> 2);
            part_byte = 8'(sym << 6);
            got       = 1'b1;
          end
          default: begin
            byte_val  = part_byte | 8'(sym);
            part_byte = '0;
            got       = 1'b1;
          end
        endcase
        sym_phase = sym_phase + 2'd1;
        if (got) begin
          if (byte_cnt == 2'd3) begin
            if (next_idx < MAX_W) begin
              have     = 1'b1;
              w        = {byte_val, word_acc};
              idx      = 12'(next_idx);
              next_idx = next_idx + 1;
            end else begin
              ovf_seen = 1'b1;
            end
            word_acc = '0;
            byte_cnt = '0;
          end else begin
            word_acc = word_acc | (24'(byte_val) << (8 * byte_cnt));
            byte_cnt = byte_cnt + 2'd1;
          end
        end
      end
    end
    // closing result, flushing a partial word when there is one
    if (b.last) begin
      valid = have;
      if (!have && byte_cnt != 2'd0) begin
        if (next_idx < MAX_W) begin
          valid = 1'b1;
          w     = {8'h00, word_acc};
          idx   = 12'(next_idx);
        end else begin
          ovf_seen = 1'b1;
        end
      end
      r.tile_word   = valid ? w : '0;
      r.word_index  = valid ? idx : '0;
      r.layer_out   = lay;
      r.word_valid  = valid;
      r.end_of_text = 1'b1;
      r.overflow    = ovf_seen;
      clear_text_state();
      return 1'b1;
    end
    if (have) begin
      r.tile_word   = w;
      r.word_index  = idx;
      r.layer_out   = lay;
      r.word_valid  = 1'b1;
      r.end_of_text = 1'b0;
      r.overflow    = ovf_seen;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // drive one beat from a falling edge and wait for it to be taken
  task automatic send_char(input char_beat_t b, input bit typed, input result_t typed_res);
    int      gap;
    result_t r;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push          <= 1'b1;
    in_char_code  <= b.ch;
    in_layer_sel  <= b.layer;
    in_first_char <= b.first;
    in_last_char  <= b.last;
    do @(posedge clk); while (full);
    if (decode_char(b, r)) pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    char_beat_t text_q [$];
    char_beat_t b;
    int         rand_count;
    int         len;
    int         kind;
    logic [3:0] lay;
    push          = 1'b0;
    in_char_code  = '0;
    in_layer_sel  = '0;
    in_first_char = 1'b0;
    in_last_char  = 1'b0;
    rst_n         = 1'b0;
    idle_on       = 1'b1;
    rand_count    = 0;
    clear_text_state();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (DIR_ROWS[i]) send_char(DIR_ROWS[i].beat, DIR_ROWS[i].typed, DIR_ROWS[i].res);

    // random texts, mostly well formed, some noise
    while (rand_count < RAND_ITEMS) begin
      text_q.delete();
      kind    = $urandom_range(0, 9);
      lay     = 4'($urandom_range(0, 15));
      idle_on = ($urandom_range(0, 5) != 0);
      if (kind < 7) begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) begin
          b.ch    = char_of($urandom_range(0, 63));
          b.layer = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(0, 15)) : lay;
          b.first = (i == 0) && ($urandom_range(0, 9) != 0);
          b.last  = 1'b0;
          text_q.push_back(b);
        end
        repeat ($urandom_range(0, 2)) begin
          b.ch    = PAD_CHAR;
          b.first = 1'b0;
          text_q.push_back(b);
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            b.ch    = 8'($urandom_range(0, 255));
            b.first = 1'b0;
            text_q.push_back(b);
          end
        end
        text_q[$].last = 1'b1;
      end else begin
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) begin
          b.ch    = 8'($urandom_range(0, 255));
          b.layer = 4'($urandom_range(0, 15));
          b.first = ($urandom_range(0, 7) == 0);
          b.last  = ($urandom_range(0, 7) == 0);
          text_q.push_back(b);
        end
      end
      foreach (text_q[i]) send_char(text_q[i], 1'b0, NO_RES);
      rand_count += text_q.size();
    end
    push    <= 1'b0;
    idle_on = 1'b1;

    // drain and settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: random stalls, check each beat against the oldest prediction
  initial begin : result_side
    int      stall;
    result_t got;
    result_t want;
    pop            = 1'b0;
    mismatch_count = 0;
    fail_count     = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.tile_word   = out_tile_word;
      got.word_index  = out_word_index;
      got.layer_out   = out_layer_out;
      got.word_valid  = out_word_valid;
      got.end_of_text = out_end_of_text;
      got.overflow    = out_overflow;
      if (pending_results.size() == 0) begin
        if (mismatch_count < SHOW_MAX)
          $display("unexpected result: word %h idx %0d layer %0d valid %b eot %b ovf %b",
                   got.tile_word, got.word_index, got.layer_out, got.word_valid,
                   got.end_of_text, got.overflow);
        mismatch_count++;
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.tile_word !== want.tile_word || got.word_index !== want.word_index ||
            got.layer_out !== want.layer_out || got.word_valid !== want.word_valid ||
            got.end_of_text !== want.end_of_text || got.overflow !== want.overflow) begin
          if (mismatch_count < SHOW_MAX) begin
            $display("mismatch exp: word %h idx %0d layer %0d valid %b eot %b ovf %b",
                     want.tile_word, want.word_index, want.layer_out, want.word_valid,
                     want.end_of_text, want.overflow);
            $display("         got: word %h idx %0d layer %0d valid %b eot %b ovf %b",
                     got.tile_word, got.word_index, got.layer_out, got.word_valid,
                     got.end_of_text, got.overflow);
          end
          mismatch_count++;
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles without any beat moving
  initial begin : watchdog
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", WDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
